// ===== rtl/qdv_pkg.sv =====
// qdv_pkg: shared types and constants for the quadrature decoder velocity unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qdv_pkg;

    // output field format
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 16;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 4 * OUT_W;
    localparam int M_TUSER_W = 2;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ANGULAR_GAIN = 1'b0;
    localparam t_cfg_idx CFG_LINEAR_GAIN  = 1'b1;

    // decoded item passed from the front end to the velocity back end
    typedef struct packed {
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] delta;
        logic             illegal;
        logic             tick;
    } t_item;

    // queue status toward the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ===== rtl/qdv_front.sv =====
// qdv_front: x4 edge decode, position count and per-tick delta capture
// depends on qdv_pkg
`timescale 1ns / 1ps

module qdv_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_pin_a,
    input  logic           i_pin_b,
    input  logic           i_velocity_tick,
    output qdv_pkg::t_item o_item
);
    import qdv_pkg::*;

    localparam int EW = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W + 1;

    logic                   r_level_a;
    logic                   r_level_b;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_last;
    logic [OUT_W-1:0]       r_delta_hold;

    logic                   ch_a;
    logic                   ch_b;
    logic                   illegal;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] diff;
    logic signed [EW-1:0]   diff_ext;
    logic signed [EW-1:0]   pos_ext;
    logic                   diff_fits;
    logic [OUT_W-1:0]       delta_sat;
    logic [OUT_W-1:0]       n_delta;

    // edge classification and direction
    always_comb begin
        ch_a    = i_pin_a ^ r_level_a;
        ch_b    = i_pin_b ^ r_level_b;
        illegal = ch_a & ch_b;
        n_count = r_count;
        if (!illegal && ch_a) begin
            n_count = (i_pin_a != r_level_b) ? r_count + 1'b1 : r_count - 1'b1;
        end else if (!illegal && ch_b) begin
            n_count = (r_level_a == i_pin_b) ? r_count + 1'b1 : r_count - 1'b1;
        end
    end

    // delta since last tick, saturated to 32 bit signed
    always_comb begin
        diff      = n_count - r_last;
        diff_ext  = EW'($signed(diff));
        pos_ext   = EW'($signed(n_count));
        diff_fits = (&diff_ext[EW-1:OUT_W-1]) | ~(|diff_ext[EW-1:OUT_W-1]);
        if (diff_fits) begin
            delta_sat = diff_ext[OUT_W-1:0];
        end else if (diff_ext[EW-1]) begin
            delta_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            delta_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
        n_delta = i_velocity_tick ? delta_sat : r_delta_hold;
    end

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_a    <= 1'b0;
            r_level_b    <= 1'b0;
            r_count      <= '0;
            r_last       <= '0;
            r_delta_hold <= '0;
        end else if (i_accept) begin
            r_level_a    <= i_pin_a;
            r_level_b    <= i_pin_b;
            r_count      <= n_count;
            r_delta_hold <= n_delta;
            if (i_velocity_tick) begin
                r_last <= n_count;
            end
        end
    end

    // item toward the queue
    always_comb begin
        o_item.position = pos_ext[OUT_W-1:0];
        o_item.delta    = n_delta;
        o_item.illegal  = illegal;
        o_item.tick     = i_velocity_tick;
    end

    // an illegal transition leaves the count alone
    a_illegal_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && illegal |=> r_count == $past(r_count))
        else $error("count moved on illegal transition");

    // a tick restarts the delta interval at the current count
    a_tick_rebase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_velocity_tick |=> r_last == r_count)
        else $error("tick did not rebase interval");

endmodule

// ===== rtl/qdv_fifo.sv =====
// qdv_fifo: short flop queue between front end and back end
// depends on qdv_pkg
`timescale 1ns / 1ps

module qdv_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  qdv_pkg::t_item      i_item,
    input  logic                i_pop,
    output qdv_pkg::t_item      o_item,
    output qdv_pkg::t_queue_stat o_stat
);
    import qdv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_fill;
    logic           do_push;
    logic           do_pop;

    assign do_push = i_push && (r_fill != CW'(DEPTH));
    assign do_pop  = i_pop && (r_fill != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_fill == CW'(DEPTH));
    assign o_stat.empty = (r_fill == '0);

    // fill level never exceeds the queue depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("queue fill level out of range");

endmodule

// ===== rtl/qdv_back.sv =====
// qdv_back: gain registers and velocity scaling pipeline (abs, multiply, scale)
// depends on qdv_pkg
`timescale 1ns / 1ps

module qdv_back #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  qdv_pkg::t_cfg_idx             i_cfg_index,
    input  logic [qdv_pkg::OUT_W-1:0]     i_cfg_data,
    input  qdv_pkg::t_queue_stat          i_stat,
    input  qdv_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qdv_pkg::M_TDATA_W-1:0] o_data,
    output logic [qdv_pkg::M_TUSER_W-1:0] o_user
);
    import qdv_pkg::*;

    localparam int PW   = 2 * OUT_W;
    localparam int SH_R = (GAIN_FRAC_BITS >= OUT_FRAC) ? GAIN_FRAC_BITS - OUT_FRAC : 0;
    localparam int SH_L = (GAIN_FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - GAIN_FRAC_BITS : 0;

    logic [OUT_W-1:0] r_angular_gain;
    logic [OUT_W-1:0] r_linear_gain;

    // stage a: sign and magnitude
    logic             r_a_valid;
    t_item            r_a_item;
    logic             r_a_neg;
    logic [OUT_W-1:0] r_a_mag;
    // stage m: products
    logic             r_m_valid;
    t_item            r_m_item;
    logic             r_m_neg;
    logic [PW-1:0]    r_m_p_ang;
    logic [PW-1:0]    r_m_p_lin;
    // stage o: output register, velocity fields double as holds
    logic             r_o_valid;
    t_item            r_o_item;
    logic [OUT_W-1:0] r_o_ang;
    logic [OUT_W-1:0] r_o_lin;

    logic             load_o;
    logic             load_m;
    logic             load_a;
    logic [OUT_W-1:0] n_ang;
    logic [OUT_W-1:0] n_lin;

    // rescale a product to q16.16, truncate toward zero, saturate, restore sign
    function automatic logic [OUT_W-1:0] scale_sat(input logic [PW-1:0] p, input logic neg);
        logic [OUT_W-1:0] limit;
        logic [PW-1:0]    ps;
        logic             sat;
        logic [OUT_W-1:0] mag;
        limit = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        ps    = (p >> SH_R) << SH_L;
        sat   = (p >> SH_R) > (PW'(limit) >> SH_L);
        mag   = sat ? limit : ps[OUT_W-1:0];
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angular_gain <= OUT_W'(65536);
            r_linear_gain  <= OUT_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ANGULAR_GAIN: r_angular_gain <= i_cfg_data;
                CFG_LINEAR_GAIN:  r_linear_gain  <= i_cfg_data;
                default:          r_angular_gain <= r_angular_gain;
            endcase
        end
    end

    // pipeline advance
    assign load_o = !r_o_valid || i_ready;
    assign load_m = !r_m_valid || load_o;
    assign load_a = !r_a_valid || load_m;
    assign o_pop  = !i_stat.empty && load_a;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (load_a) r_a_valid <= !i_stat.empty;
            if (load_m) r_m_valid <= r_a_valid;
            if (load_o) r_o_valid <= r_m_valid;
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (load_a && !i_stat.empty) begin
            r_a_item <= i_item;
            r_a_neg  <= i_item.delta[OUT_W-1];
            r_a_mag  <= i_item.delta[OUT_W-1] ? (~i_item.delta + 1'b1) : i_item.delta;
        end
    end

    // stage m payload
    always_ff @(posedge i_clk) begin
        if (load_m && r_a_valid) begin
            r_m_item  <= r_a_item;
            r_m_neg   <= r_a_neg;
            r_m_p_ang <= PW'(r_a_mag) * PW'(r_angular_gain);
            r_m_p_lin <= PW'(r_a_mag) * PW'(r_linear_gain);
        end
    end

    // velocities refresh on tick items, otherwise hold
    always_comb begin
        n_ang = r_m_item.tick ? scale_sat(r_m_p_ang, r_m_neg) : r_o_ang;
        n_lin = r_m_item.tick ? scale_sat(r_m_p_lin, r_m_neg) : r_o_lin;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_ang <= '0;
            r_o_lin <= '0;
        end else if (load_o && r_m_valid) begin
            r_o_ang <= n_ang;
            r_o_lin <= n_lin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_o && r_m_valid) begin
            r_o_item <= r_m_item;
        end
    end

    // result item: tdata position, delta, angular, linear; tuser illegal, updated
    assign o_valid = r_o_valid;
    assign o_data  = {r_o_lin, r_o_ang, r_o_item.delta, r_o_item.position};
    assign o_user  = {r_o_item.tick, r_o_item.illegal};

    // a stalled product stage keeps its products
    a_m_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !load_o |=> $stable(r_m_p_ang) && $stable(r_m_p_lin))
        else $error("product stage changed while stalled");

    // zero delta on a tick gives zero velocities
    a_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_item.tick && r_o_item.delta == '0 |-> r_o_ang == '0 && r_o_lin == '0)
        else $error("nonzero velocity for zero delta");

endmodule

// ===== rtl/quadrature_decoder_velocity_unit.sv =====
// quadrature_decoder_velocity_unit: x4 quadrature decoder with tick-based velocity
// path: an accepted item is written to the queue, then registered in stages a, m and o
// throughput: one item per cycle while the result stream is ready; a 4-entry queue decouples decode from scaling
// result stalls back up through the 3-stage scaling pipeline into the queue
// reset: synchronous active low; count, levels, holds cleared, gains set to 1.0
`timescale 1ns / 1ps

module quadrature_decoder_velocity_unit #(
    parameter int COUNT_WIDTH    = 32,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [qdv_pkg::S_TDATA_W-1:0] i_s_tdata,  // pin_a, pin_b, velocity_tick, pad
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [qdv_pkg::M_TDATA_W-1:0] o_m_tdata,  // position_count, last_delta,
                                                      // angular_velocity, linear_velocity
    output logic [qdv_pkg::M_TUSER_W-1:0] o_m_tuser,  // illegal_transition, velocity_updated
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  qdv_pkg::t_cfg_idx             i_cfg_index,
    input  logic [qdv_pkg::OUT_W-1:0]     i_cfg_data
);
    import qdv_pkg::*;

    t_item       front_item;
    t_item       queue_item;
    t_queue_stat queue_stat;
    logic        accept;
    logic        pop;

    assign o_s_tready  = !queue_stat.full;
    assign accept      = i_s_tvalid && !queue_stat.full;
    assign o_cfg_ready = 1'b1;

    // decode front end
    qdv_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_pin_a         (i_s_tdata[0]),
        .i_pin_b         (i_s_tdata[1]),
        .i_velocity_tick (i_s_tdata[2]),
        .o_item          (front_item)
    );

    // decoupling queue
    qdv_fifo #(
        .DEPTH (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_stat  (queue_stat)
    );

    // velocity back end
    qdv_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (queue_stat),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_user      (o_m_tuser)
    );

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for quadrature_decoder_velocity_unit
// depends on rtl/qdv_pkg.sv and rtl/quadrature_decoder_velocity_unit.sv
// x4 decode and tick velocity are predicted per accepted item, results checked in order
`timescale 1ns / 1ps

module tb;
    import qdv_pkg::*;

    localparam int          CNT_W       = 32;
    localparam int          GAIN_FRAC   = 16;
    localparam int          ITEMS_PHASE = 225;
    localparam int          DRAIN_WAIT  = 12;
    localparam logic [31:0] GAIN_RESET  = 32'd65536;

    typedef struct {
        logic [31:0] position;
        logic [31:0] delta;
        logic [31:0] angular;
        logic [31:0] linear;
        logic        illegal;
        logic        updated;
    } decoder_result_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index = CFG_ANGULAR_GAIN;
    logic [OUT_W-1:0]     i_cfg_data  = '0;

    // pending pin samples, bits {tick, b, a}
    logic [2:0]      pin_queue[$];
    decoder_result_t expected_results[$];
    int unsigned     errors = 0;
    logic            s_fire = 1'b0;

    // decoder copy, count width is 32 here so the delta needs no saturation
    logic              lvl_a      = 1'b0;
    logic              lvl_b      = 1'b0;
    logic [CNT_W-1:0]  count      = '0;
    logic [CNT_W-1:0]  count_tick = '0;
    logic [31:0]       delta_hold = '0;
    logic [31:0]       ang_hold   = '0;
    logic [31:0]       lin_hold   = '0;
    logic [31:0]       ang_gain   = GAIN_RESET;
    logic [31:0]       lin_gain   = GAIN_RESET;

    // idle gap bookkeeping
    int unsigned src_hold  = 0;
    int unsigned src_calm  = 0;
    int unsigned sink_hold = 0;
    int unsigned sink_calm = 0;

    // stimulus generator state
    int unsigned gray_pos = 0;
    logic        walk_dir = 1'b1;

    quadrature_decoder_velocity_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // delta times Q16.16 gain, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] scale_rate(logic [31:0] d, logic [31:0] gain);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] p;
        neg = d[31];
        mag = neg ? (64'd0 - {{32{d[31]}}, d}) : {32'd0, d};
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        p   = mag * {32'd0, gain};
        if (GAIN_FRAC >= OUT_FRAC) begin
            p = p >> (GAIN_FRAC - OUT_FRAC);
        end else if (p > (lim >> (OUT_FRAC - GAIN_FRAC))) begin
            p = lim;
        end else begin
            p = p << (OUT_FRAC - GAIN_FRAC);
        end
        if (p > lim) begin
            p = lim;
        end
        return neg ? 32'(64'd0 - p) : p[31:0];
    endfunction

    // one accepted pin sample through the x4 decoder and tick logic
    function automatic decoder_result_t advance_decoder(logic a, logic b, logic tick);
        decoder_result_t r;
        logic            ch_a;
        logic            ch_b;
        logic            bad;
        ch_a = a != lvl_a;
        ch_b = b != lvl_b;
        bad  = ch_a && ch_b;
        if (!bad && ch_a) begin
            count = (a != lvl_b) ? count + 1'b1 : count - 1'b1;
        end else if (!bad && ch_b) begin
            count = (lvl_a == b) ? count + 1'b1 : count - 1'b1;
        end
        lvl_a = a;
        lvl_b = b;
        if (tick) begin
            delta_hold = count - count_tick;
            count_tick = count;
            ang_hold   = scale_rate(delta_hold, ang_gain);
            lin_hold   = scale_rate(delta_hold, lin_gain);
        end
        r.position = count;
        r.delta    = delta_hold;
        r.angular  = ang_hold;
        r.linear   = lin_hold;
        r.illegal  = bad;
        r.updated  = tick;
        return r;
    endfunction

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // input stream driver
    always @(negedge i_clk) begin
        if (!i_s_tvalid || s_fire) begin
            if (src_hold > 0) begin
                i_s_tvalid <= 1'b0;
                src_hold--;
            end else if (pin_queue.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {{(S_TDATA_W-3){1'b0}}, pin_queue.pop_front()};
                src_hold   = pick_gap(src_calm);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result stream back pressure
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            i_m_tready <= 1'b0;
            sink_hold--;
        end else begin
            i_m_tready <= 1'b1;
            sink_hold  = pick_gap(sink_calm);
        end
    end

    // result check, then prediction of the item accepted at this edge
    always @(posedge i_clk) begin : monitor
        decoder_result_t want;
        s_fire <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("position_count", want.position, o_m_tdata[31:0]);
                    check_field("last_delta", want.delta, o_m_tdata[63:32]);
                    check_field("angular_velocity", want.angular, o_m_tdata[95:64]);
                    check_field("linear_velocity", want.linear, o_m_tdata[127:96]);
                    check_field("illegal_transition", 32'(want.illegal), 32'(o_m_tuser[0]));
                    check_field("velocity_updated", 32'(want.updated), 32'(o_m_tuser[1]));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(
                    advance_decoder(i_s_tdata[0], i_s_tdata[1], i_s_tdata[2]));
            end
        end
    end

    task automatic push_pins(input logic a, input logic b, input logic tick);
        pin_queue.push_back({tick, b, a});
    endtask

    task automatic wait_drained();
        while (pin_queue.size() != 0 || i_s_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_gain(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ANGULAR_GAIN) begin
            ang_gain = val;
        end else begin
            lin_gain = val;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // legal gray walk with random content, some holds, double flips and noise
    task automatic push_walk(input int unsigned n, input int unsigned tick_span);
        int unsigned r;
        logic        a;
        logic        b;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                walk_dir = ~walk_dir;
            end
            r = $urandom_range(0, 99);
            if (r < 78) begin
                gray_pos = walk_dir ? (gray_pos + 1) % 4 : (gray_pos + 3) % 4;
            end else if (r >= 90 && r < 96) begin
                gray_pos = (gray_pos + 2) % 4;
            end else if (r >= 96) begin
                gray_pos = $urandom_range(0, 3);
            end
            a = (gray_pos == 1) || (gray_pos == 2);
            b = (gray_pos == 2) || (gray_pos == 3);
            push_pins(a, b, $urandom_range(0, tick_span - 1) == 0);
        end
    endtask

    initial begin
        logic [31:0] ang_set [6];
        logic [31:0] lin_set [6];
        int unsigned spans   [4];
        spans = '{1, 3, 8, 32};
        ang_set[0] = 32'd0;           lin_set[0] = 32'hFFFF_FFFF;
        ang_set[1] = 32'hFFFF_FFFF;   lin_set[1] = 32'd0;
        ang_set[2] = $urandom();      lin_set[2] = $urandom();
        ang_set[3] = $urandom_range(0, 32'h000F_FFFF);
        lin_set[3] = $urandom_range(0, 32'h000F_FFFF);
        ang_set[4] = 32'd1;           lin_set[4] = 32'd196608;
        ang_set[5] = $urandom();      lin_set[5] = $urandom_range(0, 32'h0003_FFFF);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tick at rest, full forward and reverse cycles, illegal
        // double changes with and without tick, holds
        push_pins(1'b0, 1'b0, 1'b1);
        push_pins(1'b1, 1'b0, 1'b0);
        push_pins(1'b1, 1'b1, 1'b0);
        push_pins(1'b0, 1'b1, 1'b0);
        push_pins(1'b0, 1'b0, 1'b1);
        push_pins(1'b0, 1'b1, 1'b0);
        push_pins(1'b1, 1'b1, 1'b0);
        push_pins(1'b1, 1'b0, 1'b0);
        push_pins(1'b0, 1'b0, 1'b0);
        push_pins(1'b0, 1'b1, 1'b1);
        push_pins(1'b1, 1'b0, 1'b0);
        push_pins(1'b1, 1'b0, 1'b1);
        push_pins(1'b0, 1'b1, 1'b1);
        push_pins(1'b0, 1'b1, 1'b0);
        push_pins(1'b1, 1'b1, 1'b1);
        push_pins(1'b0, 1'b0, 1'b0);
        push_pins(1'b0, 1'b0, 1'b1);
        gray_pos = 0;
        wait_drained();

        // random phases, gains rewritten only while the block is idle
        for (int ph = 0; ph < 6; ph++) begin
            write_gain(CFG_ANGULAR_GAIN, ang_set[ph]);
            write_gain(CFG_LINEAR_GAIN, lin_set[ph]);
            @(posedge i_clk);
            push_walk(ITEMS_PHASE, spans[$urandom_range(0, 3)]);
            wait_drained();
        end

        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qdv_pkg.sv
rtl/qdv_front.sv
rtl/qdv_fifo.sv
rtl/qdv_back.sv
rtl/quadrature_decoder_velocity_unit.sv
verif/tb.sv
